FILE: rtl/scalar_kalman_filter_int_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the scalar Kalman filter unit
// Shared property forms, clocked on clk_i with reset rst_ni.
// ---------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_INT_UNIT_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_INT_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SKF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("skf assertion failed");

// Next-cycle implication.
`define SKF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("skf assertion failed");

`endif

FILE: rtl/skf_pkg.sv
// ---------------------------------------------------------------------------
// skf_pkg
// Widths, constants and types for the scalar Kalman filter unit.
// ---------------------------------------------------------------------------
package skf_pkg;

  // Gain scale is a power of two: 2**GAIN_LOG2.
  localparam int unsigned GAIN_LOG2  = 10;
  localparam int unsigned GAIN_SCALE = 1 << GAIN_LOG2;
  localparam int unsigned K_W        = GAIN_LOG2 + 1;      // k in 0..GAIN_SCALE
  localparam int unsigned GAIN_W     = 11;                 // gain port width
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned ERR_W      = VAL_W + 1;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned VAR_W      = 18;
  localparam int unsigned DEN_W      = VAR_W + 1;
  localparam int unsigned MB_W       = VAR_W + 1;          // signed mult operand
  localparam int unsigned PROD_W     = K_W + 1 + MB_W;
  localparam int unsigned CNT_W      = $clog2(K_W + 1);

  localparam logic [VAR_W-1:0] VAR_MAX     = {VAR_W{1'b1}};
  localparam logic [CFG_W-1:0] Q_RESET     = CFG_W'(1);
  localparam logic [CFG_W-1:0] R_RESET     = CFG_W'(100);

  typedef enum logic {
    CFG_PROCESS_NOISE     = 1'b0,
    CFG_MEASUREMENT_NOISE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDQ,
    ST_START,
    ST_DIV,
    ST_MULX,
    ST_MULP,
    ST_VARUPD,
    ST_DONE
  } state_e;

endpackage

FILE: rtl/skf_div.sv
// ---------------------------------------------------------------------------
// skf_div
// Restoring divider for the gain: p * GAIN_SCALE / max(p + r, 1), one
// quotient bit per cycle.
// ---------------------------------------------------------------------------
module skf_div import skf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAR_W-1:0] p_i,
  input  logic [CFG_W-1:0] r_i,
  output logic             done_o,
  output logic [K_W-1:0]   quo_o
);

  logic [DEN_W-1:0] den_q, rem_q, rem_d;
  logic [K_W-1:0]   nlo_q, quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DEN_W-1:0] den_sum, den_start;
  logic [DEN_W:0]   rem_sh, diff;
  logic             ge;

  assign den_sum   = DEN_W'(p_i) + DEN_W'(r_i);
  assign den_start = (den_sum == '0) ? DEN_W'(1) : den_sum;

  // quotient fits K_W bits since p <= den, so the top of the dividend
  // (p >> 1) is already below the divisor
  assign rem_sh = {rem_q, nlo_q[K_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = !diff[DEN_W];
  assign rem_d  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(K_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_start;
      rem_q <= DEN_W'(p_i) >> 1;
      nlo_q <= {p_i[0], {(K_W-1){1'b0}}};
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      nlo_q <= nlo_q << 1;
      quo_q <= {quo_q[K_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/scalar_kalman_filter_int_unit.sv
// ---------------------------------------------------------------------------
// scalar_kalman_filter_int_unit
// One-dimensional integer Kalman filter for encoder speed samples.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  in        request    in_valid_i/in_stall_o  mode_i, value_i
//  out       result     out_valid_o/out_stall_i estimate_o, gain_o
//  cfg       write      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  An update request goes from accept to result register through ST_ADDQ
//  (add q), ST_START (start the divider), ST_DIV (divide), two passes
//  through the shared multiplier (ST_MULX, ST_MULP), ST_VARUPD (write p
//  back) and ST_DONE (load the result); the next request is taken in ST_IDLE.
//  A reset request (mode 1) goes from ST_IDLE straight to ST_DONE instead.
//  The input side accepts only while the sequencer is idle; a result held
//  by out_stall_i blocks only the final write, the next request waits.
//  Reset: q = 1, r = 100, estimate = 0, variance = 100.
//
module scalar_kalman_filter_int_unit import skf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    mode_i,
  input  logic signed [VAL_W-1:0] value_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] estimate_o,
  output logic [GAIN_W-1:0]       gain_o,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

`include "scalar_kalman_filter_int_unit_defines.svh"

  state_e state_q, state_d;

  // configuration and filter state
  logic [CFG_W-1:0]        q_q, r_q;
  logic signed [VAL_W-1:0] est_q, est_d;
  logic [VAR_W-1:0]        var_q, var_d;

  // per-request working registers
  logic signed [VAL_W-1:0]  val_q;
  logic [VAR_W-1:0]         p_q;
  logic signed [ERR_W-1:0]  err_q;
  logic [K_W-1:0]           k_q;
  logic signed [PROD_W-1:0] prod_q;

  // result register
  logic                     out_valid_q;
  logic signed [VAL_W-1:0]  out_est_q;
  logic [GAIN_W-1:0]        out_gain_q;

  logic in_acc, out_free, div_start, div_done;
  logic [K_W-1:0] div_quo;

  logic [VAR_W:0]           p_sum;
  logic [VAR_W-1:0]         p_sat;
  logic signed [ERR_W-1:0]  err_new;
  logic [K_W-1:0]           mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p, prod_adj, prod_shr;
  logic [K_W+GAIN_W-1:0]    k_ext;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // p + q, saturated to the variance width
  assign p_sum   = (VAR_W+1)'(var_q) + (VAR_W+1)'(q_q);
  assign p_sat   = p_sum[VAR_W] ? VAR_MAX : p_sum[VAR_W-1:0];
  assign err_new = ERR_W'(val_q) - ERR_W'(est_q);

  // shared multiplier: k*err first, then (GAIN_SCALE-k)*p
  always_comb begin
    if (state_q == ST_MULP) begin
      mul_a = K_W'(GAIN_SCALE) - k_q;
      mul_b = $signed({1'b0, p_q});
    end else begin
      mul_a = k_q;
      mul_b = MB_W'(err_q);
    end
  end
  assign mul_p = PROD_W'($signed({1'b0, mul_a}) * mul_b);

  // divide by GAIN_SCALE truncating toward zero: bias negatives first
  assign prod_adj = prod_q + (prod_q[PROD_W-1] ? PROD_W'(GAIN_SCALE - 1) : PROD_W'(0));
  assign prod_shr = prod_adj >>> GAIN_LOG2;

  assign div_start = (state_q == ST_START);

  skf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .p_i     (p_q),
    .r_i     (r_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d = state_q;
    est_d   = est_q;
    var_d   = var_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_i) begin
            est_d   = value_i;
            var_d   = r_q;
            state_d = ST_DONE;
          end else begin
            state_d = ST_ADDQ;
          end
        end
      end
      ST_ADDQ:   state_d = ST_START;
      ST_START:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_MULX;
        end
      end
      ST_MULX:   state_d = ST_MULP;
      ST_MULP: begin
        // new estimate lies between old estimate and measurement
        est_d   = est_q + prod_shr[VAL_W-1:0];
        state_d = ST_VARUPD;
      end
      ST_VARUPD: begin
        var_d   = prod_q[GAIN_LOG2 +: VAR_W];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      q_q         <= Q_RESET;
      r_q         <= R_RESET;
      est_q       <= '0;
      var_q       <= VAR_W'(R_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      est_q   <= est_d;
      var_q   <= var_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_PROCESS_NOISE:     q_q <= cfg_data_i;
          CFG_MEASUREMENT_NOISE: r_q <= cfg_data_i;
          default:               q_q <= q_q;
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign k_ext = {{GAIN_W{1'b0}}, k_q};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_q <= value_i;
      if (mode_i) begin
        k_q <= '0;
      end
    end
    if (state_q == ST_ADDQ) begin
      p_q   <= p_sat;
      err_q <= err_new;
    end
    if (state_q == ST_DIV && div_done) begin
      k_q <= div_quo;
    end
    if (state_q == ST_MULX || state_q == ST_MULP) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_DONE && out_free) begin
      out_est_q  <= est_q;
      out_gain_q <= k_ext[GAIN_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign estimate_o  = out_est_q;
  assign gain_o      = out_gain_q;

  // an accepted request always leaves the sequencer busy next cycle
  `SKF_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o)
  // the divider only finishes while the sequencer waits on it
  `SKF_ASSERT_NOW(a_div_done_in_div, div_done, state_q == ST_DIV)
  // gain never exceeds the scale when it is written to the result
  `SKF_ASSERT_NOW(a_gain_bound, state_q == ST_DONE, k_q <= K_W'(GAIN_SCALE))
  // a reset request reloads the variance with r
  `SKF_ASSERT_NEXT(a_reset_reload, in_acc && mode_i, var_q == VAR_W'($past(r_q)))

endmodule

FILE: dv/scalar_kalman_filter_int_unit_tb.sv
// ---------------------------------------------------------------------------
// scalar_kalman_filter_int_unit_tb
// Self-checking bench for the integer 1-D Kalman filter. Requests (update or
// reset) are driven from a queue with random gaps. Results are taken under
// random stall and checked field by field against a cycle-free predictor.
// The run steps through several noise settings, the extremes among them.
// ---------------------------------------------------------------------------
module scalar_kalman_filter_int_unit_tb import skf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Request opcodes carried on mode_i.
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_RESET  = 1'b1;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                    mode;
    logic signed [VAL_W-1:0] value;
  } filter_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] estimate;
    logic [GAIN_W-1:0]       gain;
  } filter_out_t;

  // DUT connections; every input has a known value from time zero.
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic                    mode_i      = MODE_UPDATE;
  logic signed [VAL_W-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [VAL_W-1:0] estimate_o;
  logic [GAIN_W-1:0]       gain_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic                    cfg_index_i = CFG_PROCESS_NOISE;
  logic [CFG_W-1:0]        cfg_data_i  = '0;

  scalar_kalman_filter_int_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .estimate_o (estimate_o),
    .gain_o     (gain_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // -------------------------------------------------------------------------
  // Filter state as the bench sees it (mirrors the block's reset values).
  // -------------------------------------------------------------------------
  logic [CFG_W-1:0]        q_cfg     = Q_RESET;
  logic [CFG_W-1:0]        r_cfg     = R_RESET;
  logic signed [VAL_W-1:0] est_state = '0;
  logic [VAR_W-1:0]        var_state = VAR_W'(R_RESET);

  filter_req_t pending_reqs[$];   // requests not yet offered to the block
  filter_out_t expected_outs[$];  // predicted results, oldest first

  int unsigned reqs_accepted = 0;
  int unsigned results_seen  = 0;
  int unsigned cfg_writes    = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  // Idle stretches: while calm is set neither side inserts gaps or stalls.
  bit          calm       = 1'b0;
  int unsigned calm_timer = 0;
  int unsigned in_gap     = 0;
  int unsigned out_wait   = 0;

  // -------------------------------------------------------------------------
  // Predictor: one request in, next estimate and gain out. All arithmetic in
  // signed 64 bit so the divisions truncate toward zero.
  // -------------------------------------------------------------------------
  function automatic filter_out_t filter_step(filter_req_t req);
    longint      scale;
    longint      p;
    longint      den;
    longint      k;
    longint      err;
    longint      x;
    filter_out_t res;
    scale = longint'(GAIN_SCALE);
    k     = 0;
    if (req.mode == MODE_RESET) begin
      est_state = req.value;
      var_state = VAR_W'(r_cfg);
    end else begin
      p = longint'(var_state) + longint'(q_cfg);
      if (p > longint'(VAR_MAX)) p = longint'(VAR_MAX);
      den = p + longint'(r_cfg);
      if (den == 0) den = 1;           // p, q and r all zero: gain 0
      k   = (p * scale) / den;
      err = longint'(req.value) - longint'(est_state);
      x   = longint'(est_state) + (k * err) / scale;
      if (x > 32767) x = 32767;
      else if (x < -32768) x = -32768;
      est_state = VAL_W'(x);
      p         = ((scale - k) * p) / scale;
      var_state = VAR_W'(p);
    end
    res.estimate = est_state;
    res.gain     = GAIN_W'(k);
    return res;
  endfunction

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return VAL_W'(v);
  endfunction

  // -------------------------------------------------------------------------
  // Clock, reset, watchdog
  // -------------------------------------------------------------------------
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_outs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Toggle between back-to-back stretches and stretches with random gaps and stalls.
  always @(posedge clk_i) begin
    if (calm_timer == 0) begin
      calm       <= ~calm;
      calm_timer <= $urandom_range(50, 400);
    end else begin
      calm_timer <= calm_timer - 1;
    end
  end

  // -------------------------------------------------------------------------
  // Request driver: offers pending requests, holds payload while stalled,
  // and predicts the result of each accepted request.
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    filter_req_t nxt;
    filter_req_t seen;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        seen.mode  = mode_i;
        seen.value = value_i;
        expected_outs.push_back(filter_step(seen));
        reqs_accepted++;
      end
      // Free to change the payload only when nothing is held under stall.
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap     <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt        = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          mode_i     <= nxt.mode;
          value_i    <= nxt.value;
          in_gap     <= draw_wait();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result monitor: random stall per result, field compare against the
  // oldest prediction.
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    filter_out_t want;
    int unsigned w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_outs.size() == 0) begin
          $error("unexpected result: estimate %0d gain %0d", estimate_o, gain_o);
          fail_count++;
        end else begin
          want = expected_outs.pop_front();
          if (estimate_o !== want.estimate) begin
            $error("estimate: expected %0d, actual %0d", want.estimate, estimate_o);
            fail_count++;
          end
          if (gain_o !== want.gain) begin
            $error("gain: expected %0d, actual %0d", want.gain, gain_o);
            fail_count++;
          end
        end
        w = draw_wait();
        out_wait    <= w;
        out_stall_i <= (w != 0);
      end else if (out_valid_o && out_wait > 0) begin
        // Count stall cycles only while a result is actually waiting.
        out_wait    <= out_wait - 1;
        out_stall_i <= (out_wait > 1);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic push_req(input logic mode, input logic signed [VAL_W-1:0] value);
    filter_req_t req;
    req.mode  = mode;
    req.value = value;
    pending_reqs.push_back(req);
  endtask

  // Register writes happen only with the filter idle.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_PROCESS_NOISE:     q_cfg = data;
      CFG_MEASUREMENT_NOISE: r_cfg = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Sampled on the falling edge so queue updates at the rising edge are done.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pending_reqs.size() != 0 || in_valid_i || expected_outs.size() != 0);
  endtask

  // Speed track: mostly noisy updates around a drifting set point, with
  // occasional step changes, re-seeds, wild samples and rail values.
  task automatic queue_track(input int unsigned n);
    int          setpoint;
    int unsigned pick;
    setpoint = $urandom_range(0, 65535) - 32768;
    push_req(MODE_RESET, clamp16(setpoint));
    for (int unsigned i = 1; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 29) == 0) setpoint = $urandom_range(0, 65535) - 32768;
      else setpoint = setpoint + $urandom_range(0, 64) - 32;
      if (pick < 6) begin
        push_req(MODE_RESET, VAL_W'($urandom));
      end else if (pick < 75) begin
        push_req(MODE_UPDATE, clamp16(setpoint + $urandom_range(0, 400) - 200));
      end else if (pick < 92) begin
        push_req(MODE_UPDATE, VAL_W'($urandom));
      end else begin
        push_req(MODE_UPDATE, ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32768);
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] q, input logic [CFG_W-1:0] r,
                           input int unsigned n);
    write_reg(CFG_PROCESS_NOISE, q);
    write_reg(CFG_MEASUREMENT_NOISE, r);
    queue_track(n);
    wait_idle();
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);

    // Reset-value noise: rail-to-rail measurements and reloads.
    push_req(MODE_UPDATE, 16'sd32767);
    push_req(MODE_UPDATE, 16'sd32767);
    push_req(MODE_UPDATE, -16'sd32768);
    push_req(MODE_UPDATE, 16'sd0);
    push_req(MODE_RESET, 16'sd32767);
    push_req(MODE_UPDATE, -16'sd32768);  // largest negative innovation
    push_req(MODE_RESET, -16'sd32768);
    push_req(MODE_UPDATE, 16'sd32767);   // largest positive innovation
    push_req(MODE_UPDATE, -16'sd1);
    push_req(MODE_RESET, 16'sd0);
    push_req(MODE_UPDATE, 16'sd1);
    push_req(MODE_UPDATE, -16'sd1);
    wait_idle();

    // No noise at all: the variance reloads to zero and the divisor is forced.
    write_reg(CFG_PROCESS_NOISE, 16'd0);
    write_reg(CFG_MEASUREMENT_NOISE, 16'd0);
    push_req(MODE_RESET, 16'sd5);
    push_req(MODE_UPDATE, 16'sd100);
    push_req(MODE_UPDATE, -16'sd32768);
    wait_idle();

    // Perfect sensor: full gain, estimate snaps to the measurement.
    write_reg(CFG_PROCESS_NOISE, 16'hFFFF);
    push_req(MODE_UPDATE, 16'sd1234);
    push_req(MODE_UPDATE, -16'sd32768);
    push_req(MODE_UPDATE, 16'sd32767);
    wait_idle();

    // Both noises at full scale.
    write_reg(CFG_MEASUREMENT_NOISE, 16'hFFFF);
    push_req(MODE_RESET, -16'sd32768);
    push_req(MODE_UPDATE, 16'sd32767);
    push_req(MODE_UPDATE, 16'sd32767);
    wait_idle();

    // Random tracks under a range of noise settings.
    run_phase(16'd1,     16'd100,   160);
    run_phase(16'd0,     16'hFFFF,  150);
    run_phase(16'hFFFF,  16'd0,     150);
    run_phase(16'hFFFF,  16'hFFFF,  150);
    run_phase(16'd0,     16'd0,     80);
    run_phase(16'd0,     16'd1,     150);
    for (int i = 0; i < 4; i++) begin
      run_phase(CFG_W'($urandom), CFG_W'($urandom), 140);
    end

    // Let any stray result surface before the verdict.
    repeat (40) @(posedge clk_i);
    if (expected_outs.size() != 0) begin
      $error("%0d predicted results never arrived", expected_outs.size());
      fail_count++;
    end

    $display("Filtered %0d requests across %0d register writes; %0d results checked.",
             reqs_accepted, cfg_writes, results_seen);
    $display("Mismatches and protocol errors: %0d", fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
